// ===== sv/drs_pkg.sv =====
// Shared types and codes for the debounced rebuild scheduler.
package drs_pkg;

  localparam int unsigned DefTableEntries = 16;
  localparam int unsigned DefQueueDepth   = 8;
  localparam int unsigned MaxResults      = 16;
  localparam int unsigned ResW            = $clog2(MaxResults + 1);
  localparam logic [15:0] DebounceReset   = 16'd200;

  localparam logic [2:0] OP_OBSERVE = 3'd0;
  localparam logic [2:0] OP_SWEEP   = 3'd1;
  localparam logic [2:0] OP_RETURN  = 3'd2;
  localparam logic [2:0] OP_POP     = 3'd3;
  localparam logic [2:0] OP_FORGET  = 3'd4;

  localparam logic [2:0] KIND_DONE      = 3'd0;
  localparam logic [2:0] KIND_QUEUED    = 3'd1;
  localparam logic [2:0] KIND_COALESCED = 3'd2;
  localparam logic [2:0] KIND_DROPPED   = 3'd3;
  localparam logic [2:0] KIND_FULL      = 3'd4;
  localparam logic [2:0] KIND_POPPED    = 3'd5;
  localparam logic [2:0] KIND_EMPTY     = 3'd6;

  localparam logic [1:0] MODE_IDLE       = 2'd0;
  localparam logic [1:0] MODE_WAITING    = 2'd1;
  localparam logic [1:0] MODE_DISPATCHED = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] watch_id;
    logic [7:0]  dirty_gen;
    logic [31:0] now_ms;
    logic [31:0] edit_epoch;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] result_id;
    logic        last_result;
    logic [4:0]  pending_count;
    logic [4:0]  tracked_count;
    logic [3:0]  queued_count;
    logic [31:0] scheduled_total;
  } rsp_t;

  typedef struct packed {
    logic [31:0] id;
    logic [1:0]  mode;
    logic [7:0]  generation;
    logic [31:0] edit_time;
    logic        redirty;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

endpackage

// ===== sv/drs_job_fifo.sv =====
// Circular job queue with a registered read port for the coalescing search and for pop.
module drs_job_fifo import drs_pkg::*; #(
  parameter int unsigned QueueDepth = DefQueueDepth,
  localparam int unsigned QIdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned QCntW = $clog2(QueueDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  q_ctl_t           ctl_i,
  input  logic [31:0]      push_id_i,
  input  logic [QIdxW-1:0] rd_addr_i,
  output logic [31:0]      rd_id_o,
  output logic [QIdxW-1:0] head_o,
  output logic [QCntW-1:0] fill_o
);

  localparam logic [QIdxW-1:0] LastIdx = QIdxW'(QueueDepth - 1);

  logic [31:0]      mem [QueueDepth];
  logic [QIdxW-1:0] head_q, head_d, tail_q, tail_d;
  logic [QCntW-1:0] fill_q, fill_d;
  logic [31:0]      rd_q;

  function automatic logic [QIdxW-1:0] wrap_inc(input logic [QIdxW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d = ctl_i.pop  ? wrap_inc(head_q) : head_q;
    tail_d = ctl_i.push ? wrap_inc(tail_q) : tail_q;
    fill_d = fill_q + QCntW'(ctl_i.push) - QCntW'(ctl_i.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  assign rd_id_o = rd_q;
  assign head_o  = head_q;
  assign fill_o  = fill_q;

endmodule

// ===== sv/debounced_rebuild_scheduler.sv =====
// Top level of the debounced rebuild scheduler: watch table, sequencer and result port.
// The block keeps an insertion-ordered watch table and a coalescing job queue and
// handles one request at a time; in_stall_o is low only while the sequencer is idle.
// Observe (with a nonzero dirty_gen), return, forget and sweep walk the table one
// entry at a time (registered memory read, then compare); pop reads the queue head,
// then pops it. Forget also shifts every later entry down to close the gap. A sweep
// checks each table entry and, for each entry it dispatches, compares the queued
// jobs against it before queuing, coalescing or dropping the job. A result waits in
// an output register, and a sweep keeps one result back so that it can mark the
// final one. Table and queue contents need no clearing after reset: fill counts mark
// what is live, so the block takes requests from the first cycle after reset.
module debounced_rebuild_scheduler import drs_pkg::*; #(
  parameter int unsigned TableEntries = DefTableEntries,
  parameter int unsigned QueueDepth   = DefQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  req_t        in_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rsp_t        out_rsp_o
);

  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW  = $clog2(TableEntries + 1);
  localparam int unsigned QIdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW = $clog2(QueueDepth + 1);
  localparam logic [QIdxW-1:0] QLast = QIdxW'(QueueDepth - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_LK_RD, ST_LK_EV, ST_FG_RD, ST_FG_WR, ST_SW_RD, ST_SW_EV,
    ST_QS_RD, ST_QS_EV, ST_SW_DO, ST_SW_END, ST_POP_RD, ST_POP_EV, ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  req_t             req_q, req_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  tracked_q, tracked_d;
  logic [CntW-1:0]  pending_q, pending_d;
  logic [QCntW-1:0] qi_q, qi_d;
  logic [QIdxW-1:0] qptr_q, qptr_d;
  logic [ResW-1:0]  nres_q, nres_d;
  logic             bnd_q, bnd_d;
  logic [2:0]       kind_q, kind_d;
  logic [31:0]      eid_q, eid_d;
  rsp_t             hold_q, hold_d;
  logic             hold_v_q, hold_v_d;
  rsp_t             out_q, out_d;
  logic             out_v_q, out_v_d;
  logic [31:0]      sched_q, sched_d;
  logic [31:0]      saved_q, saved_d;
  logic             known_q, known_d;
  logic [15:0]      debounce_q;

  // watch table storage
  entry_t           tbl_mem [TableEntries];
  entry_t           tbl_rd_q;
  logic [IdxW-1:0]  tbl_ra;
  logic             tbl_we;
  logic [IdxW-1:0]  tbl_wa;
  entry_t           tbl_wd;

  // job queue
  q_ctl_t           q_ctl;
  logic [31:0]      q_rd;
  logic [QIdxW-1:0] q_head;
  logic [QCntW-1:0] q_fill;
  logic [QCntW-1:0] q_fill_nx;

  logic             can_emit;
  logic [31:0]      diff;
  logic             quiet;
  logic             hit;
  logic [CntW-1:0]  idx_inc;
  rsp_t             cur;
  logic [2:0]       cur_kind;
  logic [31:0]      cur_id;

  drs_job_fifo #(.QueueDepth(QueueDepth)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (q_ctl),
    .push_id_i (tbl_rd_q.id),
    .rd_addr_i (qptr_q),
    .rd_id_o   (q_rd),
    .head_o    (q_head),
    .fill_o    (q_fill)
  );

  assign can_emit   = !out_v_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign idx_inc    = idx_q + 1'b1;
  // forget shifts pull the next entry down; everything else reads the walk index
  assign tbl_ra     = (state_q == ST_FG_RD) ? idx_inc[IdxW-1:0] : idx_q[IdxW-1:0];
  assign diff       = req_q.now_ms - tbl_rd_q.edit_time;
  assign quiet      = !diff[31] && (diff >= {16'b0, debounce_q});
  assign hit        = (tbl_rd_q.id == req_q.watch_id);
  assign q_fill_nx  = q_fill + QCntW'(q_ctl.push) - QCntW'(q_ctl.pop);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    idx_d     = idx_q;
    tracked_d = tracked_q;
    pending_d = pending_q;
    qi_d      = qi_q;
    qptr_d    = qptr_q;
    nres_d    = nres_q;
    bnd_d     = bnd_q;
    kind_d    = kind_q;
    eid_d     = eid_q;
    hold_d    = hold_q;
    hold_v_d  = hold_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && out_stall_i;
    sched_d   = sched_q;
    saved_d   = saved_q;
    known_d   = known_q;
    tbl_we    = 1'b0;
    tbl_wa    = idx_q[IdxW-1:0];
    tbl_wd    = tbl_rd_q;
    q_ctl     = '0;
    cur_kind  = kind_q;
    cur_id    = eid_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d  = in_req_i;
          idx_d  = '0;
          eid_d  = '0;
          kind_d = KIND_DONE;
          case (in_req_i.operation) inside
            OP_OBSERVE: begin
              state_d = (in_req_i.dirty_gen == 8'd0) ? ST_EMIT : ST_LK_RD;
            end
            OP_RETURN, OP_FORGET: begin
              state_d = ST_LK_RD;
            end
            OP_SWEEP: begin
              bnd_d    = known_q && (in_req_i.edit_epoch != saved_q);
              saved_d  = in_req_i.edit_epoch;
              known_d  = 1'b1;
              nres_d   = '0;
              hold_v_d = 1'b0;
              state_d  = ST_SW_RD;
            end
            OP_POP: begin
              if (q_fill == '0) begin
                kind_d  = KIND_EMPTY;
                state_d = ST_EMIT;
              end else begin
                qptr_d  = q_head;
                state_d = ST_POP_RD;
              end
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end

      ST_LK_RD: begin
        if (idx_q >= tracked_q) begin
          // id not in the table
          state_d = ST_EMIT;
          if (req_q.operation == OP_OBSERVE) begin
            if (tracked_q >= CntW'(TableEntries)) begin
              kind_d = KIND_FULL;
              eid_d  = req_q.watch_id;
            end else begin
              tbl_we    = 1'b1;
              tbl_wa    = tracked_q[IdxW-1:0];
              tbl_wd    = '{id: req_q.watch_id, mode: MODE_WAITING,
                            generation: req_q.dirty_gen,
                            edit_time: req_q.now_ms, redirty: 1'b0};
              tracked_d = tracked_q + 1'b1;
              pending_d = pending_q + 1'b1;
            end
          end
        end else begin
          state_d = ST_LK_EV;
        end
      end

      ST_LK_EV: begin
        if (!hit) begin
          idx_d   = idx_inc;
          state_d = ST_LK_RD;
        end else begin
          state_d = ST_EMIT;
          case (req_q.operation)
            OP_OBSERVE: begin
              tbl_we = 1'b1;
              if (tbl_rd_q.mode == MODE_IDLE) begin
                tbl_wd.mode       = MODE_WAITING;
                tbl_wd.edit_time  = req_q.now_ms;
                tbl_wd.generation = req_q.dirty_gen;
                pending_d         = pending_q + 1'b1;
              end else if (tbl_rd_q.mode == MODE_WAITING) begin
                if (tbl_rd_q.generation != req_q.dirty_gen) begin
                  tbl_wd.edit_time  = req_q.now_ms;
                  tbl_wd.generation = req_q.dirty_gen;
                end
              end else begin
                tbl_wd.redirty    = 1'b1;
                tbl_wd.generation = req_q.dirty_gen;
              end
            end
            OP_RETURN: begin
              tbl_we = 1'b1;
              if (tbl_rd_q.redirty) begin
                tbl_wd.redirty   = 1'b0;
                tbl_wd.edit_time = req_q.now_ms;
                tbl_wd.mode      = MODE_WAITING;
                if (tbl_rd_q.mode != MODE_WAITING) begin
                  pending_d = pending_q + 1'b1;
                end
              end else begin
                tbl_wd.mode = MODE_IDLE;
                if (tbl_rd_q.mode == MODE_WAITING) begin
                  pending_d = pending_q - 1'b1;
                end
              end
            end
            default: begin
              // forget: drop the entry unless its job is out
              if (tbl_rd_q.mode != MODE_DISPATCHED) begin
                if (tbl_rd_q.mode == MODE_WAITING) begin
                  pending_d = pending_q - 1'b1;
                end
                tracked_d = tracked_q - 1'b1;
                state_d   = ST_FG_RD;
              end
            end
          endcase
        end
      end

      ST_FG_RD: begin
        state_d = (idx_q >= tracked_q) ? ST_EMIT : ST_FG_WR;
      end

      ST_FG_WR: begin
        tbl_we  = 1'b1;
        idx_d   = idx_inc;
        state_d = ST_FG_RD;
      end

      ST_SW_RD: begin
        if (idx_q >= tracked_q || nres_q == ResW'(MaxResults)) begin
          state_d = ST_SW_END;
        end else begin
          state_d = ST_SW_EV;
        end
      end

      ST_SW_EV: begin
        if (tbl_rd_q.mode == MODE_WAITING && (bnd_q || quiet)) begin
          qi_d    = '0;
          qptr_d  = q_head;
          state_d = ST_QS_RD;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_SW_RD;
        end
      end

      ST_QS_RD: begin
        if (qi_q >= q_fill) begin
          kind_d  = (q_fill >= QCntW'(QueueDepth)) ? KIND_DROPPED : KIND_QUEUED;
          state_d = ST_SW_DO;
        end else begin
          state_d = ST_QS_EV;
        end
      end

      ST_QS_EV: begin
        if (q_rd == tbl_rd_q.id) begin
          kind_d  = KIND_COALESCED;
          state_d = ST_SW_DO;
        end else begin
          qi_d    = qi_q + 1'b1;
          qptr_d  = (qptr_q == QLast) ? '0 : qptr_q + 1'b1;
          state_d = ST_QS_RD;
        end
      end

      ST_SW_DO: begin
        if (!hold_v_q || can_emit) begin
          if (hold_v_q) begin
            out_d   = hold_q;
            out_v_d = 1'b1;
          end
          tbl_we      = 1'b1;
          tbl_wd.mode = MODE_DISPATCHED;
          pending_d   = pending_q - 1'b1;
          if (kind_q == KIND_QUEUED) begin
            q_ctl.push = 1'b1;
            sched_d    = sched_q + 1'b1;
          end
          cur_id   = tbl_rd_q.id;
          hold_v_d = 1'b1;
          nres_d   = nres_q + 1'b1;
          idx_d    = idx_inc;
          state_d  = ST_SW_RD;
        end
      end

      ST_SW_END: begin
        if (can_emit) begin
          cur_kind = KIND_DONE;
          cur_id   = '0;
          out_v_d  = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_POP_RD: begin
        state_d = ST_POP_EV;
      end

      ST_POP_EV: begin
        q_ctl.pop = 1'b1;
        kind_d    = KIND_POPPED;
        eid_d     = q_rd;
        state_d   = ST_EMIT;
      end

      ST_EMIT: begin
        if (can_emit) begin
          out_v_d = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // result snapshot: counts as they stand after this cycle's action
    cur = '{event_kind: cur_kind, result_id: cur_id, last_result: 1'b1,
            pending_count: 5'(pending_d), tracked_count: 5'(tracked_d),
            queued_count: 4'(q_fill_nx), scheduled_total: sched_d};

    if (state_q == ST_EMIT && can_emit) begin
      out_d = cur;
    end
    if (state_q == ST_SW_END && can_emit) begin
      out_d = cur;
      if (hold_v_q) begin
        out_d = hold_q;
        out_d.last_result = 1'b1;
      end
    end
    if (state_q == ST_SW_DO && (!hold_v_q || can_emit)) begin
      hold_d = cur;
      hold_d.last_result = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      tracked_q  <= '0;
      pending_q  <= '0;
      qi_q       <= '0;
      qptr_q     <= '0;
      nres_q     <= '0;
      bnd_q      <= 1'b0;
      kind_q     <= KIND_DONE;
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      sched_q    <= '0;
      saved_q    <= '0;
      known_q    <= 1'b0;
      debounce_q <= DebounceReset;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      tracked_q <= tracked_d;
      pending_q <= pending_d;
      qi_q      <= qi_d;
      qptr_q    <= qptr_d;
      nres_q    <= nres_d;
      bnd_q     <= bnd_d;
      kind_q    <= kind_d;
      hold_v_q  <= hold_v_d;
      out_v_q   <= out_v_d;
      sched_q   <= sched_d;
      saved_q   <= saved_d;
      known_q   <= known_d;
      if (cfg_we_i) begin
        debounce_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    eid_q  <= eid_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    tbl_rd_q <= tbl_mem[tbl_ra];
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  a_pending_le_tracked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= tracked_q)
    else $error("more waiting entries than table entries");

  a_tracked_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tracked_q <= CntW'(TableEntries))
    else $error("table count beyond capacity");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.push |-> q_fill < QCntW'(QueueDepth))
    else $error("push into a full job queue");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ctl.pop |-> q_fill != '0)
    else $error("pop from an empty job queue");

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the debounced rebuild scheduler: directed table plus random requests.
`timescale 1ns / 1ps
module tb_top;
  import drs_pkg::*;

  localparam int NumEntries = 16;
  localparam int NumJobs    = 8;
  localparam int WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  rsp_t        out_rsp_o;

  always #5 clk_i = ~clk_i;

  debounced_rebuild_scheduler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_rsp_o(out_rsp_o)
  );

  // Shadow copy of the scheduler state.
  logic [15:0] quiet_ms;
  logic        slot_live [NumEntries];
  entry_t      slot [NumEntries];
  logic [31:0] jobs [NumJobs];
  int unsigned job_fill;
  logic [31:0] last_epoch;
  logic        epoch_seen;
  logic [31:0] jobs_ever;
  logic [2:0]  last_kind;

  rsp_t        expected_rsps[$];
  int          fail_count = 0;
  int          stall_cycles = 0;
  logic        calm = 1'b0;   // no idling on either side
  int unsigned idle_left = 0;

  function automatic int unsigned live_count();
    int unsigned n = 0;
    for (int i = 0; i < NumEntries; i++) n += slot_live[i];
    return n;
  endfunction

  function automatic int unsigned waiting_count();
    int unsigned n = 0;
    for (int i = 0; i < NumEntries; i++)
      if (slot_live[i] && slot[i].mode == MODE_WAITING) n++;
    return n;
  endfunction

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < NumEntries; i++)
      if (slot_live[i] && slot[i].id == id) return i;
    return -1;
  endfunction

  function automatic void push_rsp(logic [2:0] kind, logic [31:0] id);
    rsp_t r;
    r.event_kind      = kind;
    r.result_id       = id;
    r.last_result     = 1'b0;
    r.pending_count   = 5'(waiting_count());
    r.tracked_count   = 5'(live_count());
    r.queued_count    = 4'(job_fill);
    r.scheduled_total = jobs_ever;
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  function automatic logic [2:0] enqueue_job(logic [31:0] id);
    for (int q = 0; q < job_fill; q++)
      if (jobs[q] == id) return KIND_COALESCED;
    if (job_fill >= NumJobs) return KIND_DROPPED;
    jobs[job_fill] = id;
    job_fill++;
    jobs_ever++;
    return KIND_QUEUED;
  endfunction

  function automatic void clear_shadow();
    quiet_ms = DebounceReset;
    for (int i = 0; i < NumEntries; i++) begin
      slot_live[i] = 1'b0;
      slot[i] = '0;
    end
    job_fill = 0;
    last_epoch = '0;
    epoch_seen = 1'b0;
    jobs_ever = '0;
  endfunction

  // Work out the results of one request and append them to the expected list.
  function automatic void predict_schedule(req_t r);
    int          e;
    int          n = 0;
    int unsigned t;
    logic        edge_hit;
    logic [31:0] diff;
    logic [31:0] head;
    case (r.operation)
      OP_OBSERVE: begin
        logic [2:0]  kind = KIND_DONE;
        logic [31:0] rid = '0;
        if (r.dirty_gen != 8'd0) begin
          e = find_slot(r.watch_id);
          if (e < 0) begin
            t = live_count();
            if (t >= NumEntries) begin
              kind = KIND_FULL;
              rid = r.watch_id;
            end else begin
              slot_live[t] = 1'b1;
              slot[t].id = r.watch_id;
              slot[t].mode = MODE_WAITING;
              slot[t].generation = r.dirty_gen;
              slot[t].edit_time = r.now_ms;
              slot[t].redirty = 1'b0;
            end
          end else if (slot[e].mode == MODE_IDLE) begin
            slot[e].edit_time = r.now_ms;
            slot[e].generation = r.dirty_gen;
            slot[e].mode = MODE_WAITING;
          end else if (slot[e].mode == MODE_WAITING) begin
            if (slot[e].generation != r.dirty_gen) begin
              slot[e].edit_time = r.now_ms;
              slot[e].generation = r.dirty_gen;
            end
          end else begin
            slot[e].redirty = 1'b1;
            slot[e].generation = r.dirty_gen;
          end
        end
        push_rsp(kind, rid);
      end
      OP_SWEEP: begin
        edge_hit = epoch_seen && (r.edit_epoch != last_epoch);
        last_epoch = r.edit_epoch;
        epoch_seen = 1'b1;
        for (int i = 0; i < NumEntries && n < MaxResults; i++) begin
          if (!slot_live[i] || slot[i].mode != MODE_WAITING) continue;
          diff = r.now_ms - slot[i].edit_time;
          if (!edge_hit && (diff[31] || diff < {16'd0, quiet_ms})) continue;
          begin
            logic [2:0] k;
            k = enqueue_job(slot[i].id);
            slot[i].mode = MODE_DISPATCHED;
            push_rsp(k, slot[i].id);
            n++;
          end
        end
        if (n == 0) push_rsp(KIND_DONE, '0);
      end
      OP_RETURN: begin
        e = find_slot(r.watch_id);
        if (e >= 0) begin
          if (slot[e].redirty) begin
            slot[e].redirty = 1'b0;
            slot[e].edit_time = r.now_ms;
            slot[e].mode = MODE_WAITING;
          end else begin
            slot[e].mode = MODE_IDLE;
          end
        end
        push_rsp(KIND_DONE, '0);
      end
      OP_POP: begin
        if (job_fill == 0) begin
          push_rsp(KIND_EMPTY, '0);
        end else begin
          head = jobs[0];
          for (int q = 1; q < job_fill; q++) jobs[q-1] = jobs[q];
          job_fill--;
          push_rsp(KIND_POPPED, head);
        end
      end
      OP_FORGET: begin
        e = find_slot(r.watch_id);
        if (e >= 0 && slot[e].mode != MODE_DISPATCHED) begin
          for (int i = e; i + 1 < NumEntries; i++) begin
            slot_live[i] = slot_live[i+1];
            slot[i] = slot[i+1];
          end
          slot_live[NumEntries-1] = 1'b0;
        end
        push_rsp(KIND_DONE, '0);
      end
      default: push_rsp(KIND_DONE, '0);
    endcase
    expected_rsps[$].last_result = 1'b1;
    last_kind = expected_rsps[$].event_kind;
  endfunction

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result kind %0d id %0h", out_rsp_o.event_kind,
               out_rsp_o.result_id);
        fail_count++;
      end else begin
        rsp_t x;
        x = expected_rsps.pop_front();
        if (out_rsp_o.event_kind !== x.event_kind) begin
          $error("event_kind exp %0d got %0d", x.event_kind, out_rsp_o.event_kind);
          fail_count++;
        end
        if (out_rsp_o.result_id !== x.result_id) begin
          $error("result_id exp %0h got %0h", x.result_id, out_rsp_o.result_id);
          fail_count++;
        end
        if (out_rsp_o.last_result !== x.last_result) begin
          $error("last_result exp %0d got %0d", x.last_result, out_rsp_o.last_result);
          fail_count++;
        end
        if (out_rsp_o.pending_count !== x.pending_count) begin
          $error("pending_count exp %0d got %0d", x.pending_count,
                 out_rsp_o.pending_count);
          fail_count++;
        end
        if (out_rsp_o.tracked_count !== x.tracked_count) begin
          $error("tracked_count exp %0d got %0d", x.tracked_count,
                 out_rsp_o.tracked_count);
          fail_count++;
        end
        if (out_rsp_o.queued_count !== x.queued_count) begin
          $error("queued_count exp %0d got %0d", x.queued_count, out_rsp_o.queued_count);
          fail_count++;
        end
        if (out_rsp_o.scheduled_total !== x.scheduled_total) begin
          $error("scheduled_total exp %0h got %0h", x.scheduled_total,
                 out_rsp_o.scheduled_total);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WatchLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls in random bursts.
  always @(negedge clk_i) begin
    if (calm) begin
      out_stall_i <= 1'b0;
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall_i <= ~out_stall_i;
      idle_left <= $urandom_range(1, 16);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Send one request; hold it until accepted, then maybe idle a burst.
  task automatic send_request(req_t r);
    in_req_i <= r;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_schedule(r);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
  endtask

  // Drop valid and wait for every expected result, then settle.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_debounce(logic [15:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    quiet_ms = v;
  endtask

  function automatic req_t make_req(logic [2:0] op, logic [31:0] id, logic [7:0] g,
                                    logic [31:0] now, logic [31:0] ep);
    req_t r;
    r.operation = op;
    r.watch_id = id;
    r.dirty_gen = g;
    r.now_ms = now;
    r.edit_epoch = ep;
    return r;
  endfunction

  // Directed rows: request plus an optional typed-in kind.
  typedef struct {
    req_t       r;
    logic       fixed;
    logic [2:0] kind;
  } row_t;

  row_t        rows[$];
  logic [31:0] ids [12];
  logic [31:0] clock_ms;
  logic [31:0] epoch;
  req_t        r;

  function automatic void add_row(req_t rq, logic fixed, logic [2:0] kind);
    row_t w;
    w.r = rq;
    w.fixed = fixed;
    w.kind = kind;
    rows.insert(rows.size(), w);
  endfunction

  initial begin
    clear_shadow();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty pop, clean observe, extremes, full table, quiet and epoch
    // sweeps, drops, redirty return, forget and unused codes.
    add_row(make_req(OP_POP, 0, 0, 0, 0), 1'b1, KIND_EMPTY);
    add_row(make_req(OP_OBSERVE, 32'hFFFF_FFFF, 0, 0, 0), 1'b1, KIND_DONE);
    add_row(make_req(OP_SWEEP, 0, 0, 0, 0), 1'b1, KIND_DONE);
    for (int i = 0; i < 16; i++)
      add_row(make_req(OP_OBSERVE, i == 15 ? 32'hFFFF_FFFF : i, 8'hFF, 0, 0),
              1'b0, KIND_DONE);
    add_row(make_req(OP_OBSERVE, 32'hDEAD_BEEF, 1, 0, 0), 1'b1, KIND_FULL);
    add_row(make_req(OP_SWEEP, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, KIND_DONE);
    add_row(make_req(OP_OBSERVE, 3, 8'h80, 5, 0), 1'b0, KIND_DONE);
    add_row(make_req(OP_RETURN, 3, 0, 500, 0), 1'b1, KIND_DONE);
    add_row(make_req(OP_FORGET, 4, 0, 0, 0), 1'b1, KIND_DONE);
    add_row(make_req(OP_POP, 0, 0, 0, 0), 1'b0, KIND_DONE);
    add_row(make_req(3'd7, 0, 0, 0, 0), 1'b1, KIND_DONE);
    foreach (rows[i]) begin
      send_request(rows[i].r);
      if (rows[i].fixed && last_kind != rows[i].kind) begin
        $error("directed row %0d kind exp %0d predicted %0d", i, rows[i].kind,
               last_kind);
        fail_count++;
      end
    end
    // Clear the table: return everything, then forget, then pop the job queue empty.
    for (int i = 0; i < 16; i++) send_request(make_req(OP_RETURN, i, 0, 0, 0));
    send_request(make_req(OP_RETURN, 32'hFFFF_FFFF, 0, 0, 0));
    for (int i = 0; i < 16; i++) send_request(make_req(OP_FORGET, i, 0, 0, 0));
    send_request(make_req(OP_FORGET, 32'hFFFF_FFFF, 0, 0, 0));
    for (int i = 0; i < 9; i++) send_request(make_req(OP_POP, 0, 0, 0, 0));

    // Random part over several debounce settings, extremes included.
    clock_ms = $urandom;
    epoch = $urandom;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: write_debounce(16'd0);
        1: write_debounce(16'hFFFF);
        2: write_debounce(16'd200);
        default: write_debounce(16'($urandom_range(1, 400)));
      endcase
      foreach (ids[k]) ids[k] = (phase == 3) ? $urandom : $urandom_range(0, 20);
      if (phase == 4) calm = 1'b1;
      for (int n = 0; n < 40; n++) begin
        int pick;
        pick = $urandom_range(0, 99);
        clock_ms += $urandom_range(0, quiet_ms > 300 ? 300 : quiet_ms + 50);
        if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
        if (pick < 40)
          r = make_req(OP_OBSERVE, ids[$urandom_range(0, 11)],
                       ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 4)),
                       clock_ms, $urandom);
        else if (pick < 60) begin
          if ($urandom_range(0, 5) == 0) epoch = $urandom;
          r = make_req(OP_SWEEP, $urandom, 8'($urandom), clock_ms, epoch);
        end else if (pick < 75)
          r = make_req(OP_RETURN, ids[$urandom_range(0, 11)], 8'($urandom), clock_ms,
                       $urandom);
        else if (pick < 88)
          r = make_req(OP_POP, $urandom, 8'($urandom), clock_ms, $urandom);
        else if (pick < 97)
          r = make_req(OP_FORGET, ids[$urandom_range(0, 11)], 8'($urandom), clock_ms,
                       $urandom);
        else
          r = make_req(3'($urandom_range(5, 7)), $urandom, 8'($urandom), $urandom,
                       $urandom);
        send_request(r);
      end
      // After phase 2, pause once and wait for every expected result.
      if (phase == 2) drain_results();
    end

    in_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
